[src/bitmap_frame_allocator_core_assert.svh]
// Assertion helpers used by the checker of the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bfa_pkg.sv]
`default_nettype none

package bfa_pkg;

  // Field widths
  localparam int FRAME_W  = 20;
  localparam int SIZE_W   = 13;
  localparam int COUNT_W  = 13;
  localparam int REQ_W    = 2;
  localparam int ABS_W    = FRAME_W + 1;

  // Map geometry
  localparam int BITS_PER_WORD = 8;
  localparam int BIT_W         = $clog2(BITS_PER_WORD);
  localparam int MAP_WORDS_DEF = 512;

  // Stream words
  localparam int IN_W  = 40;
  localparam int OUT_W = 24;

  // Output word bit positions
  localparam int OUT_FOUND_BIT = FRAME_W;
  localparam int OUT_OOR_BIT   = FRAME_W + 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_FRAME = 2'd2;

  // Register reset values
  localparam logic [FRAME_W-1:0] POOL_BASE_RST  = '0;
  localparam logic [SIZE_W-1:0]  POOL_SIZE_RST  = 13'd4096;
  localparam logic [FRAME_W-1:0] INFO_FRAME_RST = '0;

endpackage

`default_nettype wire

[src/bfa_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                         wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/bitmap_frame_allocator_core.sv]
// Bitmap frame allocator.
// Requests arrive on the s_ stream (tuser = request type, tdata = first
// frame and count for a mark); each request gives exactly one word on the
// m_ stream (frame number, found, out-of-range). Pool base, pool size and
// info frame are to be written through the cfg channel only while the block
// is idle; the block itself does not enforce this. The used-bit map lives in
// one RAM of MAP_WORDS words of 8 bits, handled as read-modify-write one map
// word per cycle. A request passes the setup states S1 to S4 and GO, then
// the map walk: init clears every map word (a full pass of the RAM),
// allocate scans words until a free bit is found, at most ceil(pool/8),
// mark touches the words of the run; an empty run, an empty pool and other
// types skip the walk. The RAM port pair reads one word and writes one per
// cycle. FINISH then loads the output register; the next request is taken
// on the first edge the result word can be taken.
// After reset a clearing pass over all MAP_WORDS words marks the info frame;
// s_tready stays low meanwhile, cfg writes are taken as ever.
// A new request is accepted while a result still waits; if the receiver
// stalls, the next result is held back until the output register is free.
`default_nettype none

module bitmap_frame_allocator_core #(
  parameter int MAP_WORDS = bfa_pkg::MAP_WORDS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // requests
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [bfa_pkg::IN_W-1:0]           s_tdata,  // first_frame, mark_count
  input  wire [bfa_pkg::REQ_W-1:0]          s_tuser,  // req_type
  // results
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [bfa_pkg::OUT_W-1:0]         m_tdata,  // frame_number, found, out_of_range
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [bfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [bfa_pkg::FRAME_W-1:0]        cfg_data
);

  localparam int FW   = bfa_pkg::FRAME_W;
  localparam int XW   = bfa_pkg::ABS_W;
  localparam int BPW  = bfa_pkg::BITS_PER_WORD;
  localparam int BW   = bfa_pkg::BIT_W;
  localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP  = MAP_WORDS * BPW;
  localparam int OW   = $clog2(CAP + 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_S1     = 4'd1;
  localparam logic [3:0] ST_S2     = 4'd2;
  localparam logic [3:0] ST_S3     = 4'd3;
  localparam logic [3:0] ST_S4     = 4'd4;
  localparam logic [3:0] ST_GO     = 4'd5;
  localparam logic [3:0] ST_CLEAR  = 4'd6;
  localparam logic [3:0] ST_ALLOC  = 4'd7;
  localparam logic [3:0] ST_MARK   = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state;

  // Configuration registers
  logic [FW-1:0]               pool_base;
  logic [bfa_pkg::SIZE_W-1:0]  pool_size;
  logic [FW-1:0]               info_frame;

  // Request fields
  logic [bfa_pkg::REQ_W-1:0]   req_type;
  logic [FW-1:0]               first_frame;
  logic [bfa_pkg::COUNT_W-1:0] mark_count;

  // Setup results
  logic [OW-1:0] eff;
  logic [XW-1:0] run_end;
  logic [XW-1:0] pool_end;
  logic [FW-1:0] tgt;
  logic [FW-1:0] lo_abs;
  logic          below;
  logic [XW-1:0] hi_abs;
  logic [OW-1:0] lo;
  logic [OW-1:0] hi;
  logic          any;
  logic          info_ok;
  logic [OW-1:0] info_off;

  // Map walk
  logic [AW-1:0] cur;
  logic [AW-1:0] last;
  logic          issuing;
  logic          p_vld;
  logic [AW-1:0] p_addr;
  logic          clr_boot;

  // Results
  logic          res_found;
  logic          res_oor;
  logic [OW-1:0] hit_off;
  logic [FW-1:0] out_frame;
  logic          out_found;
  logic          out_oor;

  // RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BPW-1:0] ram_wdata;
  logic [BPW-1:0] ram_q;

  logic [BPW-1:0] free_bits;
  logic [BPW-1:0] mark_mask;
  logic [BW-1:0]  hit_bit;
  logic [OW-1:0]  hi_m1;
  logic [OW-1:0]  eff_m1;

  bfa_ram #(
    .WIDTH (BPW),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_q)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, out_oor, out_found, out_frame};
  assign hi_m1     = hi - OW'(1);
  assign eff_m1    = eff - OW'(1);

  // Per-bit view of the word read last cycle
  always_comb begin
    logic [OW-1:0] ofs;
    free_bits = '0;
    mark_mask = '0;
    hit_bit   = '0;
    for (int j = 0; j < BPW; j++) begin
      ofs = OW'({p_addr, BW'(j)});
      free_bits[j] = ~ram_q[j] & (ofs < eff);
      mark_mask[j] = (ofs >= lo) & (ofs < hi);
    end
    for (int j = BPW - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        hit_bit = BW'(j);
      end
    end
  end

  // Map write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_addr;
    ram_wdata = ram_q;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cur;
        ram_wdata = (info_ok && info_off[BW +: AW] == cur) ?
                    (BPW'(1) << info_off[BW-1:0]) : '0;
      end
      ST_ALLOC: begin
        ram_we    = p_vld && (free_bits != '0);
        ram_wdata = ram_q | (BPW'(1) << hit_bit);
      end
      ST_MARK: begin
        ram_we    = p_vld;
        ram_wdata = ram_q | mark_mask;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= bfa_pkg::POOL_BASE_RST;
      pool_size  <= bfa_pkg::POOL_SIZE_RST;
      info_frame <= bfa_pkg::INFO_FRAME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfa_pkg::REG_POOL_BASE:  pool_base  <= cfg_data;
        bfa_pkg::REG_POOL_SIZE:  pool_size  <= cfg_data[bfa_pkg::SIZE_W-1:0];
        bfa_pkg::REG_INFO_FRAME: info_frame <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      out_frame <= res_found ? (pool_base + FW'(hit_off)) : '0;
      out_found <= res_found;
      out_oor   <= res_oor;
    end
  end

  // Payload capture and setup arithmetic
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req_type    <= s_tuser;
        first_frame <= s_tdata[FW-1:0];
        mark_count  <= s_tdata[FW +: bfa_pkg::COUNT_W];
      end
      ST_S1: begin
        eff     <= (XW'(pool_size) < XW'(CAP)) ? OW'(pool_size) : OW'(CAP);
        run_end <= XW'(first_frame) + XW'(mark_count);
        tgt     <= (info_frame == '0) ? pool_base : info_frame;
      end
      ST_S2: begin
        pool_end <= XW'(pool_base) + XW'(eff);
        lo_abs   <= (first_frame < pool_base) ? pool_base : first_frame;
        below    <= (first_frame < pool_base);
      end
      ST_S3: begin
        hi_abs <= (run_end < pool_end) ? run_end : pool_end;
      end
      ST_S4: begin
        lo  <= OW'(XW'(lo_abs) - XW'(pool_base));
        hi  <= OW'(hi_abs - XW'(pool_base));
        any <= (XW'(lo_abs) < hi_abs);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur       <= '0;
      issuing   <= 1'b0;
      p_vld     <= 1'b0;
      clr_boot  <= 1'b1;
      info_ok   <= 1'b1;
      info_off  <= '0;
      res_found <= 1'b0;
      res_oor   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_S1;
          end
        end
        ST_S1: begin
          res_found <= 1'b0;
          state     <= ST_S2;
        end
        ST_S2: begin
          state <= ST_S3;
        end
        ST_S3: begin
          res_oor  <= (req_type == bfa_pkg::REQ_MARK) && (mark_count != '0) &&
                      (below || run_end > pool_end);
          info_ok  <= (tgt >= pool_base) && (XW'(tgt) < pool_end);
          info_off <= OW'(tgt - pool_base);
          state    <= ST_S4;
        end
        ST_S4: begin
          state <= ST_GO;
        end
        ST_GO: begin
          p_vld <= 1'b0;
          case (req_type)
            bfa_pkg::REQ_INIT: begin
              cur   <= '0;
              state <= ST_CLEAR;
            end
            bfa_pkg::REQ_ALLOC: begin
              cur     <= '0;
              last    <= eff_m1[BW +: AW];
              issuing <= (eff != '0);
              state   <= (eff != '0) ? ST_ALLOC : ST_FINISH;
            end
            bfa_pkg::REQ_MARK: begin
              cur     <= lo[BW +: AW];
              last    <= hi_m1[BW +: AW];
              issuing <= any;
              state   <= any ? ST_MARK : ST_FINISH;
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end
        ST_CLEAR: begin
          if (cur == LAST_WORD) begin
            cur      <= '0;
            clr_boot <= 1'b0;
            state    <= clr_boot ? ST_IDLE : ST_FINISH;
          end else begin
            cur <= cur + AW'(1);
          end
        end
        ST_ALLOC: begin
          if (p_vld && free_bits != '0) begin
            hit_off   <= OW'({p_addr, hit_bit});
            res_found <= 1'b1;
            issuing   <= 1'b0;
            p_vld     <= 1'b0;
            state     <= ST_FINISH;
          end else if (!issuing) begin
            // last word checked without a free bit
            p_vld <= 1'b0;
            state <= ST_FINISH;
          end else begin
            p_vld  <= 1'b1;
            p_addr <= cur;
            if (cur == last) begin
              issuing <= 1'b0;
            end else begin
              cur <= cur + AW'(1);
            end
          end
        end
        ST_MARK: begin
          if (issuing) begin
            p_vld  <= 1'b1;
            p_addr <= cur;
            if (cur == last) begin
              issuing <= 1'b0;
            end else begin
              cur <= cur + AW'(1);
            end
          end else begin
            p_vld <= 1'b0;
            if (!p_vld) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/bfa_checker.sv]
`default_nettype none

`include "bitmap_frame_allocator_core_assert.svh"

// Port-level checks of the frame allocator.
module bfa_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tvalid,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [bfa_pkg::OUT_W-1:0]  m_tdata
);

  logic found_bit;
  logic oor_bit;

  assign found_bit = m_tdata[bfa_pkg::OUT_FOUND_BIT];
  assign oor_bit   = m_tdata[bfa_pkg::OUT_OOR_BIT];

  // a stalled result word holds
  `BFA_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // an allocate hit never carries a range flag
  `BFA_ASSERT_IMP(a_excl, clk, rst, m_tvalid, !(found_bit && oor_bit), "found and out_of_range both set")

  // no frame number without a hit
  `BFA_ASSERT_IMP(a_zero, clk, rst, m_tvalid && !found_bit, m_tdata[bfa_pkg::FRAME_W-1:0] == '0, "frame number without found")

  // one request at a time
  `BFA_ASSERT_NXT(a_one, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted while busy")

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
